// ===== rtl/epoch_seconds_to_calendar_date_unit_assert.svh =====
// Assertion macros shared by the calendar date unit.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EPCAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EPCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/epcal_pkg.sv =====
// Types, constants and the month table of the calendar date unit.
`default_nettype none

package epcal_pkg;

  localparam int unsigned ZONE_W  = 17;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned NUM_W   = 33;  // local time after the offset, clamped at zero
  localparam int unsigned QUO_W   = 27;  // widest quotient is the count of minutes
  localparam int unsigned OPD_W   = 17;  // shared subtractor operand width
  localparam int unsigned MUL_W   = 32;  // shared multiplier operand width

  localparam logic [ZONE_W-1:0] ZONE_RESET = 17'h18F80;  // -28800

  // Dividing by 60 is a shift right by two followed by a reciprocal multiply for 15.
  // Each reciprocal is exact over the widest dividend its division can see.
  localparam logic [MUL_W-1:0] RECIP_15       = 32'h8888_8889;
  localparam int unsigned      RECIP_15_SH    = 35;
  localparam logic [MUL_W-1:0] RECIP_BLOCK    = 32'd3919660;
  localparam int unsigned      RECIP_BLOCK_SH = 37;
  localparam logic [MUL_W-1:0] RECIP_DAY      = 32'd21846;
  localparam int unsigned      RECIP_DAY_SH   = 19;

  localparam logic [MUL_W-1:0] SECS_PER_MIN    = 32'd60;
  localparam logic [MUL_W-1:0] HOURS_PER_BLOCK = 32'd35064;  // 1461 days
  localparam logic [MUL_W-1:0] HOURS_PER_DAY   = 32'd24;
  localparam logic [OPD_W-1:0] HOURS_COMMON    = 17'd8760;
  localparam logic [OPD_W-1:0] HOURS_LEAP      = 17'd8784;

  localparam logic [7:0] FIRST_YEAR = 8'd70;
  localparam logic [8:0] LEAP_DAY   = 9'd60;
  localparam logic [3:0] FEBRUARY   = 4'd1;
  localparam logic [3:0] DECEMBER   = 4'd11;
  localparam logic [8:0] LEAP_DOM   = 9'd29;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_QUO,
    ST_PROD,
    ST_REM,
    ST_YEAR,
    ST_ADJ,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Which of the four divisions the quotient, product and remainder steps work on.
  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_BLK,
    DIV_DAY
  } div_t;

  typedef struct packed {
    logic             ge;    // a >= b
    logic [OPD_W-1:0] diff;  // a - b, meaningful when ge
  } sub_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/epcal_sub.sv =====
// Shared subtract and compare unit for the remainder, year and month steps.
`default_nettype none

module epcal_sub (
  input  wire logic [epcal_pkg::OPD_W-1:0] a,
  input  wire logic [epcal_pkg::OPD_W-1:0] b,
  output epcal_pkg::sub_res_t              res
);

  logic [epcal_pkg::OPD_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[epcal_pkg::OPD_W];
  assign res.diff = wide[epcal_pkg::OPD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_date_unit.sv =====
// Top level: seconds since 1970 to calendar date on a shared multiplier and subtractor.
//
//   channel  ports                                 handshake
//   input    start, busy, in_epoch_seconds         taken when start && !busy
//   result   out_valid, out_second .. out_day_*    one-cycle strobe, cannot stall
//   config   cfg_valid, cfg_ready, cfg_zone_offset taken when valid && ready
//
// Each of the four divisions runs a reciprocal quotient step, a quotient times divisor step
// and a remainder step; the rest is an offset step, the year steps, a leap adjust, the
// month steps and the strobe. busy is high from the cycle after acceptance through the
// strobe cycle.
// Reset is synchronous and clears the sequencer and the zone offset to -28800.
// cfg_ready is always high; the user must write the offset only while the unit is idle, the block does not enforce it.
`default_nettype none

module epoch_seconds_to_calendar_date_unit (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [31:0] in_epoch_seconds,
  output logic              out_valid,
  output logic [5:0]        out_second,
  output logic [5:0]        out_minute,
  output logic [4:0]        out_hour,
  output logic [7:0]        out_year_since_1900,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day_of_month,
  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic signed [16:0] cfg_zone_offset
);

  `include "epoch_seconds_to_calendar_date_unit_assert.svh"

  epcal_pkg::state_t state_r, state_nxt;
  epcal_pkg::div_t   stage_r, stage_nxt;
  logic [epcal_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [epcal_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [epcal_pkg::OPD_W-1:0]   prod_r, prod_nxt;
  logic [epcal_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [epcal_pkg::ZONE_W-1:0]  zone_r;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [15:0] inblk_r, inblk_nxt;
  logic [8:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic [epcal_pkg::OPD_W-1:0]   sub_a, sub_b;
  epcal_pkg::sub_res_t           sub_res;
  logic [epcal_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*epcal_pkg::MUL_W-1:0] mul_p;
  logic [epcal_pkg::MUL_W-1:0]   divisor;
  logic [epcal_pkg::QUO_W-1:0]   quo_est;
  logic [33:0]                   local_t;
  logic                          leap;
  logic                          date_ok;
  logic                          time_ok;

  epcal_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  assign mul_p = {{epcal_pkg::MUL_W{1'b0}}, mul_a} * {{epcal_pkg::MUL_W{1'b0}}, mul_b};
  assign leap  = (year_r[1:0] == 2'b00);

  // The offset is sign-extended; a negative local time clamps to zero.
  assign local_t = {2'b00, epoch_r} - {{17{zone_r[epcal_pkg::ZONE_W-1]}}, zone_r};

  always_comb begin
    case (stage_r)
      epcal_pkg::DIV_BLK: begin
        divisor = epcal_pkg::HOURS_PER_BLOCK;
        quo_est = mul_p[epcal_pkg::RECIP_BLOCK_SH +: epcal_pkg::QUO_W];
      end
      epcal_pkg::DIV_DAY: begin
        divisor = epcal_pkg::HOURS_PER_DAY;
        quo_est = mul_p[epcal_pkg::RECIP_DAY_SH +: epcal_pkg::QUO_W];
      end
      default: begin
        divisor = epcal_pkg::SECS_PER_MIN;
        quo_est = mul_p[epcal_pkg::RECIP_15_SH +: epcal_pkg::QUO_W];
      end
    endcase
  end

  // The quotient is the high part of the dividend times a reciprocal; the next step
  // multiplies it back by the divisor so the remainder falls out of one subtraction.
  always_comb begin
    case (state_r)
      epcal_pkg::ST_QUO: begin
        case (stage_r)
          epcal_pkg::DIV_SEC: begin
            mul_a = {1'b0, num_r[32:2]};
            mul_b = epcal_pkg::RECIP_15;
          end
          epcal_pkg::DIV_MIN: begin
            mul_a = {7'd0, num_r[26:2]};
            mul_b = epcal_pkg::RECIP_15;
          end
          epcal_pkg::DIV_BLK: begin
            mul_a = {11'd0, num_r[20:0]};
            mul_b = epcal_pkg::RECIP_BLOCK;
          end
          default: begin
            mul_a = {18'd0, num_r[13:0]};
            mul_b = epcal_pkg::RECIP_DAY;
          end
        endcase
      end
      epcal_pkg::ST_PROD: begin
        mul_a = {5'd0, quo_r};
        mul_b = divisor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      // Only the low bits matter: the true remainder always fits the operand width.
      epcal_pkg::ST_REM: begin
        sub_a = num_r[epcal_pkg::OPD_W-1:0];
        sub_b = prod_r;
      end
      epcal_pkg::ST_YEAR: begin
        sub_a = {1'b0, inblk_r};
        sub_b = leap ? epcal_pkg::HOURS_LEAP : epcal_pkg::HOURS_COMMON;
      end
      epcal_pkg::ST_MONTH: begin
        sub_a = {8'd0, day_r};
        sub_b = {12'd0, epcal_pkg::month_len(mon_r)};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    prod_nxt  = prod_r;
    epoch_nxt = epoch_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    year_nxt  = year_r;
    inblk_nxt = inblk_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    case (state_r)
      epcal_pkg::ST_IDLE: begin
        if (start) begin
          epoch_nxt = in_epoch_seconds;
          state_nxt = epcal_pkg::ST_LOCAL;
        end
      end
      epcal_pkg::ST_LOCAL: begin
        num_nxt   = local_t[33] ? '0 : local_t[epcal_pkg::NUM_W-1:0];
        stage_nxt = epcal_pkg::DIV_SEC;
        state_nxt = epcal_pkg::ST_QUO;
      end
      epcal_pkg::ST_QUO: begin
        quo_nxt   = quo_est;
        state_nxt = epcal_pkg::ST_PROD;
      end
      epcal_pkg::ST_PROD: begin
        prod_nxt  = mul_p[epcal_pkg::OPD_W-1:0];
        state_nxt = epcal_pkg::ST_REM;
      end
      epcal_pkg::ST_REM: begin
        case (stage_r)
          epcal_pkg::DIV_SEC: begin
            sec_nxt   = sub_res.diff[5:0];
            num_nxt   = {6'd0, quo_r};
            stage_nxt = epcal_pkg::DIV_MIN;
            state_nxt = epcal_pkg::ST_QUO;
          end
          epcal_pkg::DIV_MIN: begin
            min_nxt   = sub_res.diff[5:0];
            num_nxt   = {6'd0, quo_r};
            stage_nxt = epcal_pkg::DIV_BLK;
            state_nxt = epcal_pkg::ST_QUO;
          end
          epcal_pkg::DIV_BLK: begin
            year_nxt  = epcal_pkg::FIRST_YEAR + {quo_r[5:0], 2'b00};
            inblk_nxt = sub_res.diff[15:0];
            state_nxt = epcal_pkg::ST_YEAR;
          end
          default: begin
            hour_nxt  = sub_res.diff[4:0];
            day_nxt   = quo_r[8:0] + 9'd1;
            state_nxt = epcal_pkg::ST_ADJ;
          end
        endcase
      end
      epcal_pkg::ST_YEAR: begin
        if (sub_res.ge) begin
          inblk_nxt = sub_res.diff[15:0];
          year_nxt  = year_r + 8'd1;
        end else begin
          num_nxt   = {17'd0, inblk_r};
          stage_nxt = epcal_pkg::DIV_DAY;
          state_nxt = epcal_pkg::ST_QUO;
        end
      end
      epcal_pkg::ST_ADJ: begin
        mon_nxt = '0;
        // The leap day is resolved here; days after it fold onto the common table.
        if (leap && (day_r == epcal_pkg::LEAP_DAY)) begin
          mon_nxt   = epcal_pkg::FEBRUARY;
          day_nxt   = epcal_pkg::LEAP_DOM;
          state_nxt = epcal_pkg::ST_DONE;
        end else begin
          if (leap && (day_r > epcal_pkg::LEAP_DAY)) begin
            day_nxt = day_r - 9'd1;
          end
          state_nxt = epcal_pkg::ST_MONTH;
        end
      end
      epcal_pkg::ST_MONTH: begin
        if ((mon_r < epcal_pkg::DECEMBER) && sub_res.ge && (sub_res.diff != '0)) begin
          day_nxt = sub_res.diff[8:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = epcal_pkg::ST_DONE;
        end
      end
      epcal_pkg::ST_DONE: begin
        state_nxt = epcal_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = epcal_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epcal_pkg::ST_IDLE;
      zone_r  <= epcal_pkg::ZONE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        zone_r <= cfg_zone_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    prod_r  <= prod_nxt;
    epoch_r <= epoch_nxt;
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hour_r  <= hour_nxt;
    year_r  <= year_nxt;
    inblk_r <= inblk_nxt;
    day_r   <= day_nxt;
    mon_r   <= mon_nxt;
  end

  assign busy                = (state_r != epcal_pkg::ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = (state_r == epcal_pkg::ST_DONE);
  assign out_second          = sec_r;
  assign out_minute          = min_r;
  assign out_hour            = hour_r;
  assign out_year_since_1900 = year_r;
  assign out_month           = mon_r;
  assign out_day_of_month    = day_r[4:0];

  assign date_ok = (out_month <= epcal_pkg::DECEMBER) && (out_day_of_month != 5'd0);
  assign time_ok = (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24);

  `EPCAL_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid && !busy, "result strobe not single")
  `EPCAL_ASSERT_NEXT(a_start_busy, start && !busy, busy && !out_valid, "accepted word not held")
  `EPCAL_ASSERT_NOW(a_date_range, out_valid, date_ok, "date out of range")
  `EPCAL_ASSERT_NOW(a_time_range, out_valid, time_ok, "time out of range")

endmodule

`default_nettype wire
